### design/brmr_pkg.sv
// ----------------------------------------------------------------------------
// brmr_pkg
// Shared types and constants for the broadcast ring with several readers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brmr_pkg;

    // Default configuration
    localparam int CAPACITY_DEF  = 16;
    localparam int SUBS_DEF      = 8;
    localparam int MSG_BITS_DEF  = 32;

    // Fixed field widths on the request and result channels
    localparam int OP_W     = 3;
    localparam int ID_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 5;
    localparam int LAG_W    = 32;

    // Lag counter saturates here
    localparam logic [LAG_W-1:0] LAG_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_SEND        = 3'd0,
        OP_RECEIVE     = 3'd1,
        OP_SUBSCRIBE   = 3'd2,
        OP_UNSUBSCRIBE = 3'd3,
        OP_CLEAR       = 3'd4,
        OP_QUERY       = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_READER = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NO_ID     = 2'd3
    } status_t;

    // Command from the ring control to the reader table
    typedef struct packed {
        logic              en;
        op_t               op;
        logic [ID_W-1:0]   id;
        logic              ring_full;
    } brmr_cmd_t;

    // Reader table answer for the addressed reader
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   assigned_id;
        logic [LAG_W-1:0]  lag_reported;
        logic [PEND_W-1:0] pending;
        logic [LAG_W-1:0]  lag_now;
        logic              is_empty;
        logic              is_full;
        logic              recv_ok;
    } brmr_rpt_t;

endpackage

### design/brmr_req_if.sv
// ----------------------------------------------------------------------------
// brmr_req_if
// Request channel: operation, reader id and message word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brmr_req_if;
    import brmr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   subscriber_id;
    logic [WORD_W-1:0] message;

    modport source (output valid, op, subscriber_id, message, input ready);
    modport sink   (input valid, op, subscriber_id, message, output ready);
endinterface

### design/brmr_rsp_if.sv
// ----------------------------------------------------------------------------
// brmr_rsp_if
// Result channel: status and the addressed reader's state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brmr_rsp_if;
    import brmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned_id;
    logic [WORD_W-1:0]   message_out;
    logic [LAG_W-1:0]    lag_reported;
    logic [PEND_W-1:0]   pending;
    logic [LAG_W-1:0]    lag_now;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, status, assigned_id, message_out, lag_reported,
                    pending, lag_now, is_empty, is_full, input ready);
    modport sink   (input valid, status, assigned_id, message_out, lag_reported,
                    pending, lag_now, is_empty, is_full, output ready);
endinterface

### design/brmr_readers.sv
// ----------------------------------------------------------------------------
// brmr_readers
// Reader table: valid marks, read positions and lag counters (the last two
// updated in parallel on a send into a full ring), plus the addressed reader's report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brmr_readers #(
    parameter int  CAPACITY        = brmr_pkg::CAPACITY_DEF,
    parameter int  MAX_SUBSCRIBERS = brmr_pkg::SUBS_DEF,
    localparam int POS_W           = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  brmr_pkg::brmr_cmd_t cmd,
    input  logic [POS_W-1:0]    fill_now,
    input  logic [POS_W-1:0]    fill_next,
    output logic [POS_W-1:0]    recv_pos,
    output brmr_pkg::brmr_rpt_t rpt
);
    import brmr_pkg::*;

    localparam int RID_W = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
    localparam int IDX_W = (RID_W > ID_W) ? RID_W : ID_W;

    logic [MAX_SUBSCRIBERS-1:0] valid_reg;
    logic [MAX_SUBSCRIBERS-1:0] valid_next;
    logic [POS_W-1:0]           pos_reg  [MAX_SUBSCRIBERS];
    logic [POS_W-1:0]           pos_next [MAX_SUBSCRIBERS];
    logic [LAG_W-1:0]           lag_reg  [MAX_SUBSCRIBERS];
    logic [LAG_W-1:0]           lag_next [MAX_SUBSCRIBERS];

    logic [IDX_W-1:0] id_wide;
    logic             in_range;
    logic [RID_W-1:0] idx;
    logic             present;
    logic [POS_W-1:0] cur_pos;
    logic [LAG_W-1:0] cur_lag;
    logic             free_found;
    logic [RID_W-1:0] free_idx;
    logic [IDX_W-1:0] free_wide;
    logic             recv_ok;

    logic             rep_present;
    logic [POS_W-1:0] rep_pos;
    logic [LAG_W-1:0] rep_lag;

    // Addressed reader lookup
    assign id_wide  = IDX_W'(cmd.id);
    assign in_range = ({1'b0, id_wide} < (IDX_W + 1)'(MAX_SUBSCRIBERS));
    assign idx      = id_wide[RID_W-1:0];
    assign present  = in_range && valid_reg[idx];
    assign cur_pos  = pos_reg[idx];
    assign cur_lag  = lag_reg[idx];
    assign recv_pos = cur_pos;
    assign recv_ok  = (cmd.op == OP_RECEIVE) && present && (cur_pos < fill_now);

    // Lowest free id
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = MAX_SUBSCRIBERS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = RID_W'(k);
            end
        end
    end

    assign free_wide = IDX_W'(free_idx);

    // Per-reader next state
    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < MAX_SUBSCRIBERS; k++)
        begin
            pos_next[k] = pos_reg[k];
            lag_next[k] = lag_reg[k];
            if (cmd.en)
            begin
                unique case (cmd.op)
                    OP_SEND:
                    begin
                        // oldest entry dropped: step back, or count a miss
                        if (cmd.ring_full && valid_reg[k])
                        begin
                            if (pos_reg[k] != '0)
                                pos_next[k] = pos_reg[k] - 1'b1;
                            else if (lag_reg[k] != LAG_MAX)
                                lag_next[k] = lag_reg[k] + 1'b1;
                        end
                    end
                    OP_RECEIVE:
                    begin
                        if (recv_ok && idx == RID_W'(k))
                        begin
                            pos_next[k] = pos_reg[k] + 1'b1;
                            lag_next[k] = '0;
                        end
                    end
                    OP_SUBSCRIBE:
                    begin
                        if (free_found && free_idx == RID_W'(k))
                        begin
                            valid_next[k] = 1'b1;
                            pos_next[k]   = fill_now;
                            lag_next[k]   = '0;
                        end
                    end
                    OP_UNSUBSCRIBE:
                    begin
                        if (present && idx == RID_W'(k))
                            valid_next[k] = 1'b0;
                    end
                    OP_CLEAR:
                    begin
                        if (present && idx == RID_W'(k))
                        begin
                            pos_next[k] = fill_now;
                            lag_next[k] = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Report of the addressed reader after the step
    always_comb
    begin
        rpt              = '0;
        rpt.status       = ST_OK;
        rpt.recv_ok      = recv_ok;
        rep_present      = present;
        rep_pos          = cur_pos;
        rep_lag          = cur_lag;
        unique case (cmd.op)
            OP_SEND:
            begin
                if (cmd.ring_full)
                begin
                    if (cur_pos != '0)
                        rep_pos = cur_pos - 1'b1;
                    else if (cur_lag != LAG_MAX)
                        rep_lag = cur_lag + 1'b1;
                end
            end
            OP_RECEIVE:
            begin
                if (!present)
                    rpt.status = ST_NO_READER;
                else if (!recv_ok)
                    rpt.status = ST_EMPTY;
                else
                begin
                    rpt.lag_reported = cur_lag;
                    rep_pos          = cur_pos + 1'b1;
                    rep_lag          = '0;
                end
            end
            OP_SUBSCRIBE:
            begin
                if (free_found)
                begin
                    rpt.assigned_id = free_wide[ID_W-1:0];
                    rep_present     = 1'b1;
                    rep_pos         = fill_now;
                    rep_lag         = '0;
                end
                else
                begin
                    rpt.status  = ST_NO_ID;
                    rep_present = 1'b0;
                end
            end
            OP_UNSUBSCRIBE:
            begin
                if (!present)
                    rpt.status = ST_NO_READER;
                rep_present = 1'b0;
            end
            OP_CLEAR:
            begin
                if (!present)
                    rpt.status = ST_NO_READER;
                else
                begin
                    rep_pos = fill_now;
                    rep_lag = '0;
                end
            end
            default:
            begin
                if (!present)
                    rpt.status = ST_NO_READER;
            end
        endcase

        if (rep_present)
        begin
            rpt.pending  = (rep_pos < fill_next) ? PEND_W'(fill_next - rep_pos) : '0;
            rpt.lag_now  = rep_lag;
            rpt.is_empty = (rep_pos >= fill_next);
            rpt.is_full  = (fill_next == POS_W'(CAPACITY)) && (rep_pos == '0);
        end
        else
        begin
            rpt.is_empty = 1'b1;
        end
    end

    // Valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Positions and lag counters, only meaningful while valid
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_SUBSCRIBERS; k++)
        begin
            pos_reg[k] <= pos_next[k];
            lag_reg[k] <= lag_next[k];
        end
    end

endmodule

### design/broadcast_ring_multi_reader_unit.sv
// ----------------------------------------------------------------------------
// broadcast_ring_multi_reader_unit
// Broadcast ring of CAPACITY message words with up to MAX_SUBSCRIBERS readers.
// One request is taken per clock cycle. Its result passes through the first
// stage and then the output register before it is presented on the result
// channel. The result is driven from the output register; the message RAM
// read port is loaded at the accepting edge alongside the first stage.
// Requests stall only while both stages hold results that the result side
// has not yet taken. The ring overwrites its oldest word when full; readers
// that were sitting on that word get their lag counter bumped instead. There
// is no clearing pass after reset: ring words are only read once written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module broadcast_ring_multi_reader_unit #(
    parameter int CAPACITY        = brmr_pkg::CAPACITY_DEF,
    parameter int MAX_SUBSCRIBERS = brmr_pkg::SUBS_DEF,
    parameter int MESSAGE_BITS    = brmr_pkg::MSG_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brmr_req_if.sink  req,
    brmr_rsp_if.source rsp
);
    import brmr_pkg::*;

    localparam int POS_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W  = POS_W + 1;

    // Ring pointers
    logic [SLOT_W-1:0] oldest_slot_reg;
    logic [SLOT_W-1:0] oldest_slot_next;
    logic [POS_W-1:0]  fill_count_reg;
    logic [POS_W-1:0]  fill_count_next;

    // Message RAM and its registered read port
    logic [MESSAGE_BITS-1:0] message_store [CAPACITY];
    logic [MESSAGE_BITS-1:0] rd_data_reg;

    logic              accept;
    op_t               op_in;
    logic              ring_full;
    logic              is_send;
    brmr_cmd_t         cmd;
    brmr_rpt_t         rpt;
    logic [POS_W-1:0]  recv_pos;

    logic [SUM_W-1:0]  wsum;
    logic [SUM_W-1:0]  rsum;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
    logic [63:0]       msg_wide;
    logic [63:0]       rd_wide;
    logic [MESSAGE_BITS-1:0] wdata;
    logic [WORD_W-1:0] rd_word;

    // Result pipeline
    logic              s1_valid_reg;
    logic              s1_valid_next;
    brmr_rpt_t         s1_rpt_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    brmr_rpt_t         out_rpt_reg;
    logic [WORD_W-1:0] out_msg_reg;
    logic              s1_adv;

    // Handshake
    assign accept    = req.valid && req.ready;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;

    assign op_in     = op_t'(req.op);
    assign ring_full = (fill_count_reg == POS_W'(CAPACITY));
    assign is_send   = accept && (op_in == OP_SEND);

    assign cmd.en        = accept;
    assign cmd.op        = op_in;
    assign cmd.id        = req.subscriber_id;
    assign cmd.ring_full = ring_full;

    brmr_readers #(
        .CAPACITY        (CAPACITY),
        .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS)
    ) u_readers (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .fill_now  (fill_count_reg),
        .fill_next (fill_count_next),
        .recv_pos  (recv_pos),
        .rpt       (rpt)
    );

    // Ring pointer update
    always_comb
    begin
        oldest_slot_next = oldest_slot_reg;
        fill_count_next  = fill_count_reg;
        if (is_send)
        begin
            if (ring_full)
                oldest_slot_next = (oldest_slot_reg == SLOT_W'(CAPACITY - 1)) ?
                                   '0 : oldest_slot_reg + 1'b1;
            else
                fill_count_next = fill_count_reg + 1'b1;
        end
    end

    // Slot addresses: oldest plus offset, wrapped once
    assign wsum  = SUM_W'(oldest_slot_reg) + SUM_W'(fill_count_reg);
    assign rsum  = SUM_W'(oldest_slot_reg) + SUM_W'(recv_pos);
    assign waddr = (wsum >= SUM_W'(CAPACITY)) ? SLOT_W'(wsum - SUM_W'(CAPACITY))
                                              : SLOT_W'(wsum);
    assign raddr = (rsum >= SUM_W'(CAPACITY)) ? SLOT_W'(rsum - SUM_W'(CAPACITY))
                                              : SLOT_W'(rsum);

    assign msg_wide = 64'(req.message);
    assign wdata    = msg_wide[MESSAGE_BITS-1:0];
    assign rd_wide  = 64'(rd_data_reg);
    assign rd_word  = rd_wide[WORD_W-1:0];

    // Message RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (is_send)
            message_store[waddr] <= wdata;
        if (accept && rpt.recv_ok)
            rd_data_reg <= message_store[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_slot_reg <= '0;
            fill_count_reg  <= '0;
        end
        else
        begin
            oldest_slot_reg <= oldest_slot_next;
            fill_count_reg  <= fill_count_next;
        end
    end

    // Pipeline valids
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload; the RAM word joins the report at the output register
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_rpt_reg <= rpt;
        if (s1_adv)
        begin
            out_rpt_reg <= s1_rpt_reg;
            out_msg_reg <= s1_rpt_reg.recv_ok ? rd_word : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_rpt_reg.status;
    assign rsp.assigned_id  = out_rpt_reg.assigned_id;
    assign rsp.message_out  = out_msg_reg;
    assign rsp.lag_reported = out_rpt_reg.lag_reported;
    assign rsp.pending      = out_rpt_reg.pending;
    assign rsp.lag_now      = out_rpt_reg.lag_now;
    assign rsp.is_empty     = out_rpt_reg.is_empty;
    assign rsp.is_full      = out_rpt_reg.is_full;

`ifndef SYNTHESIS
    // Fill count never exceeds the ring size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= POS_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // Oldest slot only moves once the ring has filled
    a_oldest_still: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg != POS_W'(CAPACITY)) |-> (oldest_slot_reg == '0))
        else $error("oldest slot moved before ring was full");

    // A send into a ring with room grows it by one
    a_send_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (is_send && !ring_full) |=> (fill_count_reg == $past(fill_count_reg) + 1'b1))
        else $error("send did not grow the ring");

    // A failed request carries no message and no lag report
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
        (rsp.message_out == '0 && rsp.lag_reported == '0))
        else $error("failed request delivered data");
`endif

endmodule
